// File: rtl/mouse_packet_cursor_tracker_assert.svh
// Assertion helpers for the mouse cursor tracker.
// Each macro takes a label, an antecedent, a consequent and a message string.
`ifndef MOUSE_PACKET_CURSOR_TRACKER_ASSERT_SVH
`define MOUSE_PACKET_CURSOR_TRACKER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define MPCT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define MPCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MPCT_ASSERT_NOW(label, ante, cons, msg)

`define MPCT_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: rtl/mpct_pkg.sv
package mpct_pkg;

  localparam int MAX_COLUMNS = 128;
  localparam int MAX_ROWS    = 64;

  localparam logic [7:0] COL_LIMIT = 8'(MAX_COLUMNS);
  localparam logic [6:0] ROW_LIMIT = 7'(MAX_ROWS);

  // Configuration register indexes.
  localparam logic [1:0] REG_ENABLED = 2'd0;
  localparam logic [1:0] REG_COLUMNS = 2'd1;
  localparam logic [1:0] REG_ROWS    = 2'd2;

  // Reset values.
  localparam logic [7:0] COLUMNS_RESET  = 8'd80;
  localparam logic [6:0] ROWS_RESET     = 7'd25;
  localparam logic [6:0] CURSOR_X_RESET = 7'd40;
  localparam logic [5:0] CURSOR_Y_RESET = 6'd12;

  // Bit positions inside the status byte.
  localparam int SYNC_BIT    = 3;
  localparam int X_SIGN_BIT  = 4;
  localparam int Y_SIGN_BIT  = 5;
  localparam int LEFT_BIT    = 0;

  typedef enum logic {
    OP_BYTE    = 1'b0,
    OP_CONSUME = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    POS_STATUS = 2'd0,
    POS_X      = 2'd1,
    POS_Y      = 2'd2
  } byte_pos_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } in_item_t;

  typedef struct packed {
    logic [6:0] pos_x;
    logic [5:0] pos_y;
    logic [2:0] button_bits;
    logic       moved_flag;
    logic       clicked_flag;
    logic       packet_done;
  } out_item_t;

endpackage

// File: rtl/mouse_packet_cursor_tracker.sv
// A result is registered in the output register, or in the skid register
// while the output stalls. Throughput: one request per cycle while the
// skid register is empty; the state update is a single add or subtract and
// clamp per axis, and the skid register takes one request during a stall.
// Reset (rst, synchronous, active high) restores cursor 40,12, screen 80x25,
// tracking disabled, and empties the output and skid registers.
`include "mouse_packet_cursor_tracker_assert.svh"

module mouse_packet_cursor_tracker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [1:0]            cfg_index,
  input  logic [7:0]            cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  mpct_pkg::in_item_t    in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output mpct_pkg::out_item_t   out_item
);
  import mpct_pkg::*;

  logic       enabled;
  logic [7:0] columns;
  logic [6:0] rows;

  byte_pos_t  byte_pos, byte_pos_next;
  logic [7:0] status_byte, status_byte_next;
  logic [7:0] x_delta_byte, x_delta_byte_next;
  logic [6:0] cursor_x, cursor_x_next;
  logic [5:0] cursor_y, cursor_y_next;
  logic [2:0] latched_buttons, latched_buttons_next;
  logic       moved_sticky, moved_sticky_next;
  logic       clicked_sticky, clicked_sticky_next;
  logic       done;

  out_item_t  result;
  out_item_t  skid_item;
  logic       skid_valid;

  logic       in_fire;
  logic       out_fire;

  logic [7:0] cap_x;
  logic [6:0] cap_y;
  logic [6:0] top_x;
  logic [5:0] top_y;
  logic [9:0] sum_x;
  logic [9:0] diff_y;
  logic [6:0] clamped_x;
  logic [5:0] clamped_y;

  assign in_stall = skid_valid | rst;
  assign in_fire  = in_valid & ~in_stall;
  assign out_fire = out_valid & ~out_stall;

  // Largest legal coordinate; screens of size 0 or 1 pin the axis to 0.
  always_comb begin
    cap_x = (columns > COL_LIMIT) ? COL_LIMIT : columns;
    cap_y = (rows > ROW_LIMIT) ? ROW_LIMIT : rows;
    top_x = (cap_x < 8'd2) ? 7'd0 : 7'(cap_x - 8'd1);
    top_y = (cap_y < 7'd2) ? 6'd0 : 6'(cap_y - 7'd1);
  end

  // Deltas are nine-bit two's complement, extended here to ten bits.
  always_comb begin
    sum_x  = {3'b000, cursor_x}
           + {status_byte[X_SIGN_BIT], status_byte[X_SIGN_BIT], x_delta_byte};
    diff_y = {4'b0000, cursor_y}
           - {status_byte[Y_SIGN_BIT], status_byte[Y_SIGN_BIT], in_item.data};

    if (sum_x[9]) begin
      clamped_x = 7'd0;
    end else if (sum_x[8:0] > {2'b00, top_x}) begin
      clamped_x = top_x;
    end else begin
      clamped_x = sum_x[6:0];
    end

    if (diff_y[9]) begin
      clamped_y = 6'd0;
    end else if (diff_y[8:0] > {3'b000, top_y}) begin
      clamped_y = top_y;
    end else begin
      clamped_y = diff_y[5:0];
    end
  end

  always_comb begin
    byte_pos_next        = byte_pos;
    status_byte_next     = status_byte;
    x_delta_byte_next    = x_delta_byte;
    cursor_x_next        = cursor_x;
    cursor_y_next        = cursor_y;
    latched_buttons_next = latched_buttons;
    moved_sticky_next    = moved_sticky;
    clicked_sticky_next  = clicked_sticky;
    done                 = 1'b0;

    if (in_fire) begin
      if (in_item.op == OP_CONSUME) begin
        moved_sticky_next   = 1'b0;
        clicked_sticky_next = 1'b0;
      end else if (enabled) begin
        case (byte_pos)
          POS_STATUS: begin
            // A first byte without the always-one bit is dropped to resync.
            if (in_item.data[SYNC_BIT]) begin
              status_byte_next = in_item.data;
              byte_pos_next    = POS_X;
            end
          end
          POS_X: begin
            x_delta_byte_next = in_item.data;
            byte_pos_next     = POS_Y;
          end
          POS_Y: begin
            byte_pos_next        = POS_STATUS;
            cursor_x_next        = clamped_x;
            cursor_y_next        = clamped_y;
            latched_buttons_next = status_byte[2:0];
            moved_sticky_next    = 1'b1;
            if (status_byte[LEFT_BIT]) begin
              clicked_sticky_next = 1'b1;
            end
            done = 1'b1;
          end
          default: begin
            byte_pos_next = POS_STATUS;
          end
        endcase
      end
    end

    result.pos_x        = cursor_x_next;
    result.pos_y        = cursor_y_next;
    result.button_bits  = latched_buttons_next;
    result.moved_flag   = moved_sticky_next;
    result.clicked_flag = clicked_sticky_next;
    result.packet_done  = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b0;
      columns <= COLUMNS_RESET;
      rows    <= ROWS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ENABLED: enabled <= cfg_data[0];
        REG_COLUMNS: columns <= cfg_data;
        REG_ROWS:    rows    <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos        <= POS_STATUS;
      status_byte     <= 8'd0;
      x_delta_byte    <= 8'd0;
      cursor_x        <= CURSOR_X_RESET;
      cursor_y        <= CURSOR_Y_RESET;
      latched_buttons <= 3'd0;
      moved_sticky    <= 1'b0;
      clicked_sticky  <= 1'b0;
    end else begin
      byte_pos        <= byte_pos_next;
      status_byte     <= status_byte_next;
      x_delta_byte    <= x_delta_byte_next;
      cursor_x        <= cursor_x_next;
      cursor_y        <= cursor_y_next;
      latched_buttons <= latched_buttons_next;
      moved_sticky    <= moved_sticky_next;
      clicked_sticky  <= clicked_sticky_next;
    end
  end

  // Output register with one skid entry behind it. While the skid entry is
  // full no request is accepted, so it drains before anything new arrives.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_fire || !out_valid) begin
      if (skid_valid) begin
        out_item   <= skid_item;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (in_fire) begin
        out_item  <= result;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (in_fire) begin
      skid_item  <= result;
      skid_valid <= 1'b1;
    end
  end

  `MPCT_ASSERT_NOW(a_skid_behind_output, skid_valid, out_valid, "skid full with output empty")
  `MPCT_ASSERT_NEXT(a_consume_clears, in_fire && (in_item.op == OP_CONSUME), !moved_sticky && !clicked_sticky, "consume did not clear sticky flags")
  `MPCT_ASSERT_NEXT(a_packet_sets_moved, done, moved_sticky && (byte_pos == POS_STATUS), "completed packet left moved flag or position wrong")
  `MPCT_ASSERT_NEXT(a_cursor_clamped, done, (cursor_x <= $past(top_x)) && (cursor_y <= $past(top_y)), "cursor outside screen after packet")

endmodule
